// ===== rtl/qps_pkg.sv =====
package qps_pkg;

   typedef enum logic [1:0] {
      MODE_FIRST     = 2'd0,
      MODE_KEY_EMPTY = 2'd1,
      MODE_KEY       = 2'd2,
      MODE_VALUE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_type;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // one result item
   typedef struct packed {
      logic [7:0] data;
      logic       is_value;
      logic       field_end;
   } res_type;

   // result list under construction, one slot beyond the output limit
   typedef struct packed {
      logic [2:0]       n;
      res_type [3:0]    e;
   } acc_type;

   typedef struct packed {
      acc_type  acc;
      mode_type mode;
      esc_type  esc;
   } step_type;

   function automatic logic is_hex(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'h00;
         if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
         end
         return v[3:0];
      end
   endfunction

   function automatic logic ends_value(logic [7:0] c);
      return c == CH_AMP || c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic acc_type put(acc_type a, logic [7:0] b, logic isv, logic fe);
      acc_type r;
      begin
         r = a;
         if (a.n < 3'd4) begin
            r.e[a.n[1:0]].data      = b;
            r.e[a.n[1:0]].is_value  = isv;
            r.e[a.n[1:0]].field_end = fe;
            r.n = a.n + 3'd1;
         end
         return r;
      end
   endfunction

   // value byte with no escape pending
   function automatic step_type value_plain(step_type s, logic [7:0] b);
      step_type r;
      begin
         r = s;
         if (b == CH_PCT) begin
            r.esc = ESC_PCT;
         end else if (b == CH_PLUS) begin
            r.acc = put(r.acc, CH_SPACE, 1'b1, 1'b0);
         end else if (ends_value(b)) begin
            r.acc  = put(r.acc, CH_NUL, 1'b1, 1'b1);
            r.mode = MODE_KEY_EMPTY;
         end else begin
            r.acc = put(r.acc, b, 1'b1, 1'b0);
         end
         return r;
      end
   endfunction

endpackage

// ===== rtl/query_param_split_and_percent_decode.sv =====
// the first result item is registered and appears in the cycle after its input item is accepted
// one input item per cycle while each yields at most one result and rsp_tready stays high;
//    an input item yielding several results holds off the input while they drain
// the three-slot result buffer sets the rate; the next item is taken as its last slot drains
// reset: synchronous, active high; clears parse state and empties the result buffer
module query_param_split_and_percent_decode
   import qps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] is_value, [1] field_end
   output logic       rsp_tlast
);

   mode_type   mode_ff, mode_in;
   esc_type    esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] cnt_ff, cnt_in;
   res_type    res_ff [3];
   res_type    res_in [3];

   logic       accept;
   logic       take;
   step_type   s;
   logic [7:0] held;
   logic       skip;

   assign take       = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = res_ff[0].data;
   assign rsp_tuser  = {res_ff[0].field_end, res_ff[0].is_value};
   assign rsp_tlast  = cnt_ff == 2'd1;

   // decode of one input byte against the current parse state
   always_comb begin
      s.acc  = '0;
      s.mode = mode_ff;
      s.esc  = esc_ff;
      held   = held_ff;
      skip   = 1'b0;
      if (mode_ff == MODE_FIRST) begin
         s.mode = MODE_KEY_EMPTY;
         skip   = req_tdata == CH_QUEST;
      end
      if (skip) begin
         s.esc = esc_ff;
      end else if (s.mode != MODE_VALUE) begin
         if (req_tdata == CH_EQ) begin
            s.acc  = put(s.acc, CH_NUL, 1'b0, 1'b1);
            s.mode = MODE_VALUE;
            s.esc  = ESC_NONE;
         end else begin
            s.acc  = put(s.acc, req_tdata, 1'b0, 1'b0);
            s.mode = MODE_KEY;
         end
      end else begin
         case (esc_ff)
            ESC_PCT: begin
               if (is_hex(req_tdata)) begin
                  held  = req_tdata;
                  s.esc = ESC_DIGIT;
               end else begin
                  s.acc = put(s.acc, CH_PCT, 1'b1, 1'b0);
                  s.esc = ESC_NONE;
                  s     = value_plain(s, req_tdata);
               end
            end
            ESC_DIGIT: begin
               if (is_hex(req_tdata)) begin
                  s.acc = put(s.acc, {hex_val(held_ff), hex_val(req_tdata)}, 1'b1, 1'b0);
                  s.esc = ESC_NONE;
               end else begin
                  s.acc = put(s.acc, CH_PCT, 1'b1, 1'b0);
                  s.acc = put(s.acc, held_ff, 1'b1, 1'b0);
                  s.esc = ESC_NONE;
                  s     = value_plain(s, req_tdata);
               end
            end
            default: begin
               s.esc = ESC_NONE;
               s     = value_plain(s, req_tdata);
            end
         endcase
      end

      // end of string: flush pending escape, close the open field
      if (req_tlast) begin
         if (s.mode == MODE_VALUE) begin
            if (s.esc == ESC_PCT || s.esc == ESC_DIGIT) begin
               s.acc = put(s.acc, CH_PCT, 1'b1, 1'b0);
            end
            if (s.esc == ESC_DIGIT) begin
               s.acc = put(s.acc, held, 1'b1, 1'b0);
            end
            s.acc = put(s.acc, CH_NUL, 1'b1, 1'b1);
         end else if (s.mode == MODE_KEY) begin
            s.acc = put(s.acc, CH_NUL, 1'b0, 1'b1);
            s.acc = put(s.acc, CH_NUL, 1'b1, 1'b1);
         end
         s.mode = MODE_FIRST;
         s.esc  = ESC_NONE;
         held   = CH_NUL;
      end

      // four results: the third result gives way to the final one
      if (s.acc.n == 3'd4) begin
         s.acc.e[2] = s.acc.e[3];
         s.acc.n    = 3'd3;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      esc_in    = esc_ff;
      held_in   = held_ff;
      cnt_in    = cnt_ff;
      res_in[0] = res_ff[0];
      res_in[1] = res_ff[1];
      res_in[2] = res_ff[2];
      if (accept) begin
         mode_in   = s.mode;
         esc_in    = s.esc;
         held_in   = held;
         cnt_in    = s.acc.n[1:0];
         res_in[0] = s.acc.e[0];
         res_in[1] = s.acc.e[1];
         res_in[2] = s.acc.e[2];
      end else if (take) begin
         cnt_in    = cnt_ff - 2'd1;
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIRST;
         esc_ff  <= ESC_NONE;
         held_ff <= CH_NUL;
         cnt_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
      res_ff[2] <= res_in[2];
   end

endmodule
